// ===== hw/rtl/itad_pkg.sv =====
// ----------------------------------------------------------------------------
// itad_pkg
// Shared types, constants and the digit-to-character function of the
// integer to ASCII digits unit.
// ----------------------------------------------------------------------------
`default_nettype none

package itad_pkg;

  localparam int unsigned MAX_DIGITS_DEF = 32;
  localparam int unsigned VALUE_W        = 64;
  localparam int unsigned MODE_W         = 2;
  localparam int unsigned DCNT_W         = 6;
  localparam int unsigned CHAR_W         = 8;
  localparam int unsigned NIB_W          = 4;
  // decimal digits needed for the largest 64-bit value
  localparam int unsigned DEC_DIGITS     = 20;

  localparam logic [MODE_W-1:0] MODE_SDEC = 2'd0;
  localparam logic [MODE_W-1:0] MODE_UDEC = 2'd1;
  localparam logic [MODE_W-1:0] MODE_HEX  = 2'd2;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_UPPER = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_LOWER = 8'h61;

  typedef struct packed {
    logic load;   // capture an accepted word
    logic shift;  // one double-dabble step
    logic step;   // move to the next lower digit
  } itad_cmd_t;

  typedef struct packed {
    logic in_zero;  // offered word asks for no digits
    logic in_hex;   // offered word is hexadecimal
    logic last;     // current digit is the least significant one
  } itad_sts_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [NIB_W-1:0] d,
                                                   input logic upper);
    logic [CHAR_W-1:0] ext;
    ext = {{(CHAR_W-NIB_W){1'b0}}, d};
    if (d < 4'd10) begin
      digit_char = CHAR_ZERO + ext;
    end else if (upper) begin
      digit_char = CHAR_UPPER + ext - 8'd10;
    end else begin
      digit_char = CHAR_LOWER + ext - 8'd10;
    end
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/itad_if.sv =====
// ----------------------------------------------------------------------------
// itad_if
// Valid/ready channels of the integer to ASCII digits unit: request words
// in, one character word out per digit.
// ----------------------------------------------------------------------------
`default_nettype none

interface itad_in_if;
  logic                          valid;
  logic                          ready;
  logic [itad_pkg::MODE_W-1:0]   mode;
  logic [itad_pkg::VALUE_W-1:0]  value;
  logic [itad_pkg::DCNT_W-1:0]   digit_count;
  logic                          upper_case;

  modport source (output valid, mode, value, digit_count, upper_case, input ready);
  modport sink   (input valid, mode, value, digit_count, upper_case, output ready);
endinterface

interface itad_out_if;
  logic                          valid;
  logic                          ready;
  logic [itad_pkg::CHAR_W-1:0]   character;
  logic                          last;

  modport source (output valid, character, last, input ready);
  modport sink   (input valid, character, last, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/itad_dp.sv =====
// ----------------------------------------------------------------------------
// itad_dp
// Datapath: magnitude capture, double-dabble binary to BCD converter,
// digit register and down-counting digit index.
// ----------------------------------------------------------------------------
`default_nettype none

module itad_dp #(
  parameter int unsigned MAX_DIGITS = itad_pkg::MAX_DIGITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire itad_pkg::itad_cmd_t           cmd_i,
  output      itad_pkg::itad_sts_t           sts_o,
  input  wire logic [itad_pkg::MODE_W-1:0]   mode_i,
  input  wire logic [itad_pkg::VALUE_W-1:0]  value_i,
  input  wire logic [itad_pkg::DCNT_W-1:0]   digit_count_i,
  input  wire logic                          upper_case_i,
  output      logic [itad_pkg::CHAR_W-1:0]   character_o
);

  localparam int unsigned IDX_W   = $clog2(MAX_DIGITS);
  localparam int unsigned CNT_W   = itad_pkg::DCNT_W + 1;
  localparam int unsigned DIG_N   = itad_pkg::DEC_DIGITS;
  localparam int unsigned DIG_W   = itad_pkg::NIB_W * DIG_N;
  localparam int unsigned DSEL_W  = $clog2(DIG_N);
  localparam int unsigned VW      = itad_pkg::VALUE_W;

  logic [VW-1:0]    bin_q, bin_d;
  logic [DIG_W-1:0] dig_q, dig_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic             upper_q, upper_d;

  logic [CNT_W-1:0] cnt_ext;
  logic [CNT_W-1:0] cnt_clamp;
  logic [VW-1:0]    mag;
  logic [DIG_W-1:0] dig_adj;
  logic [itad_pkg::NIB_W-1:0] nib;

  always_comb begin
    cnt_ext   = {1'b0, digit_count_i};
    cnt_clamp = (cnt_ext > CNT_W'(MAX_DIGITS)) ? CNT_W'(MAX_DIGITS) : cnt_ext;
    mag       = ((mode_i == itad_pkg::MODE_SDEC) && value_i[VW-1]) ?
                (VW'(0) - value_i) : value_i;
  end

  // add three to every BCD digit of five or more before the shift
  always_comb begin
    for (int i = 0; i < DIG_N; i++) begin
      if (dig_q[i*4 +: 4] >= 4'd5) begin
        dig_adj[i*4 +: 4] = dig_q[i*4 +: 4] + 4'd3;
      end else begin
        dig_adj[i*4 +: 4] = dig_q[i*4 +: 4];
      end
    end
  end

  always_comb begin
    bin_d   = bin_q;
    dig_d   = dig_q;
    idx_d   = idx_q;
    upper_d = upper_q;
    if (cmd_i.load) begin
      idx_d   = IDX_W'(cnt_clamp - CNT_W'(1));
      upper_d = upper_case_i;
      bin_d   = mag;
      if (mode_i[1]) begin
        dig_d = {{(DIG_W-VW){1'b0}}, value_i};
      end else begin
        dig_d = '0;
      end
    end else if (cmd_i.shift) begin
      dig_d = {dig_adj[DIG_W-2:0], bin_q[VW-1]};
      bin_d = {bin_q[VW-2:0], 1'b0};
    end else if (cmd_i.step) begin
      idx_d = idx_q - IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_q   <= '0;
      dig_q   <= '0;
      idx_q   <= '0;
      upper_q <= 1'b0;
    end else begin
      bin_q   <= bin_d;
      dig_q   <= dig_d;
      idx_q   <= idx_d;
      upper_q <= upper_d;
    end
  end

  // positions above the decimal capacity always read as zero
  always_comb begin
    if (idx_q < IDX_W'(DIG_N)) begin
      nib = dig_q[idx_q[DSEL_W-1:0]*4 +: 4];
    end else begin
      nib = '0;
    end
    character_o = itad_pkg::digit_char(nib, upper_q);
  end

  always_comb begin
    sts_o.in_zero = (digit_count_i == '0);
    sts_o.in_hex  = mode_i[1];
    sts_o.last    = (idx_q == '0);
  end

endmodule

`default_nettype wire

// ===== hw/rtl/itad_ctrl.sv =====
// ----------------------------------------------------------------------------
// itad_ctrl
// Controller: accepts a request word, runs the binary to BCD conversion
// for decimal modes and paces the character words out.
// ----------------------------------------------------------------------------
`default_nettype none

module itad_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output      logic                 in_ready_o,
  output      logic                 out_valid_o,
  input  wire logic                 out_ready_i,
  input  wire itad_pkg::itad_sts_t  sts_i,
  output      itad_pkg::itad_cmd_t  cmd_o
);

  localparam int unsigned BIT_W = $clog2(itad_pkg::VALUE_W);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONVERT,
    ST_EMIT
  } state_e;

  state_e           state_q;
  logic [BIT_W-1:0] bit_q;
  logic             in_ready_q;
  logic             out_valid_q;

  assign in_ready_o  = in_ready_q;
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o.load  = in_valid_i & in_ready_q;
    cmd_o.shift = (state_q == ST_CONVERT);
    cmd_o.step  = out_valid_q & out_ready_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      bit_q       <= '0;
      in_ready_q  <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          // a word asking for no digits is dropped
          if (cmd_o.load && !sts_i.in_zero) begin
            in_ready_q <= 1'b0;
            bit_q      <= '0;
            if (sts_i.in_hex) begin
              state_q     <= ST_EMIT;
              out_valid_q <= 1'b1;
            end else begin
              state_q <= ST_CONVERT;
            end
          end
        end
        ST_CONVERT: begin
          bit_q <= bit_q + BIT_W'(1);
          if (bit_q == '1) begin
            state_q     <= ST_EMIT;
            out_valid_q <= 1'b1;
          end
        end
        ST_EMIT: begin
          if (cmd_o.step && sts_i.last) begin
            state_q     <= ST_IDLE;
            out_valid_q <= 1'b0;
            in_ready_q  <= 1'b1;
          end
        end
        default: begin
          state_q     <= ST_IDLE;
          in_ready_q  <= 1'b1;
          out_valid_q <= 1'b0;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_ready_xor_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_q && out_valid_q))
    else $error("request accepted while characters are pending");

  a_no_out_convert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CONVERT) |-> !out_valid_q)
    else $error("character offered during conversion");

  a_busy_after_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.load && !sts_i.in_zero) |=> !in_ready_q)
    else $error("still ready after taking a request");

  a_ready_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.step && sts_i.last) |=> (in_ready_q && !out_valid_q))
    else $error("not idle after the final character");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/integer_to_ascii_digits_unit.sv =====
// ----------------------------------------------------------------------------
// integer_to_ascii_digits_unit
// Converts a 64-bit value to a run of ASCII decimal or hexadecimal digits.
//
// A request word on in_i carries the value, the mode (signed decimal
// magnitude, unsigned decimal, hexadecimal), the hex letter case and the
// digit count. The unit answers with digit_count character words on out_o,
// most significant first, zero padded, last set on the final one. Counts
// above MAX_DIGITS keep the low-order MAX_DIGITS digits; a count of zero
// gives no words.
// Hexadecimal: the first character is offered in the cycle after acceptance.
// Decimal: a double-dabble pass over the value comes first, and the first
// character is offered once it ends. After that one character goes out per
// cycle while out_o is ready. in_i.ready is low from acceptance until the
// final word is taken. A stalled receiver simply holds the current
// character. Reset returns the unit to idle with in_i.ready high and
// nothing offered.
// ----------------------------------------------------------------------------
`default_nettype none

module integer_to_ascii_digits_unit #(
  parameter int unsigned MAX_DIGITS = itad_pkg::MAX_DIGITS_DEF
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  itad_in_if.sink     in_i,
  itad_out_if.source  out_o
);

  itad_pkg::itad_cmd_t cmd;
  itad_pkg::itad_sts_t sts;
  logic                in_ready;
  logic                out_valid;
  logic [itad_pkg::CHAR_W-1:0] character;

  itad_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  itad_dp #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .mode_i        (in_i.mode),
    .value_i       (in_i.value),
    .digit_count_i (in_i.digit_count),
    .upper_case_i  (in_i.upper_case),
    .character_o   (character)
  );

  assign in_i.ready      = in_ready;
  assign out_o.valid     = out_valid;
  assign out_o.character = character;
  assign out_o.last      = sts.last;

endmodule

`default_nettype wire

// ===== verif/integer_to_ascii_digits_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_to_ascii_digits_unit_tb
// Self-checking bench for the integer to ASCII digits unit. A table of
// directed requests (extremes, every mode, letter case, zero and oversized
// digit counts) runs first, then randomised requests. Each accepted request
// is expanded into its expected character words by a local digit generator,
// or by the typed string where the table gives one. Every character word
// taken from the unit is compared with the oldest expected word. Both sides
// stall in random bursts, except in the final stretch of the run.
// ----------------------------------------------------------------------------

module integer_to_ascii_digits_unit_tb;

  localparam int unsigned    DIGIT_CAP     = itad_pkg::MAX_DIGITS_DEF;
  localparam logic [itad_pkg::MODE_W-1:0] MODE_HEX_ALT = 2'd3;  // also hexadecimal
  localparam int unsigned    RANDOM_WORDS  = 350;
  localparam int unsigned    QUIET_WORDS   = 50;
  localparam int unsigned    DRAIN_CYCLES  = 150;
  localparam int unsigned    WATCHDOG_MAX  = 2000;

  typedef struct {
    logic [itad_pkg::MODE_W-1:0]  mode;
    logic [itad_pkg::VALUE_W-1:0] value;
    logic [itad_pkg::DCNT_W-1:0]  count;
    logic                         upper;
    bit                           typed;
    string                        text;
  } conv_row_t;

  typedef struct {
    logic [itad_pkg::CHAR_W-1:0] ch;
    logic                        last;
  } char_word_t;

  logic clk_i;
  logic rst_ni;

  itad_in_if  req_if ();
  itad_out_if chr_if ();

  integer_to_ascii_digits_unit #(
    .MAX_DIGITS(DIGIT_CAP)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (req_if),
    .out_o (chr_if)
  );

  char_word_t  char_expect_q[$];
  conv_row_t   conv_rows[$];
  int unsigned fail_cnt;
  int unsigned stall_left;
  int unsigned quiet_cnt;
  bit          idle_en;

  always #5 clk_i = ~clk_i;

  // Expand one request into its digit characters, most significant first.
  function automatic void predict_digits(input logic [itad_pkg::MODE_W-1:0] mode,
                                         input logic [itad_pkg::VALUE_W-1:0] value,
                                         input logic [itad_pkg::DCNT_W-1:0] count,
                                         input logic upper);
    logic [itad_pkg::VALUE_W-1:0] mag;
    logic [itad_pkg::CHAR_W-1:0]  digits[DIGIT_CAP];
    logic [itad_pkg::NIB_W-1:0]   nib;
    int unsigned                  n;
    char_word_t                   w;
    n   = (32'(count) > DIGIT_CAP) ? DIGIT_CAP : 32'(count);
    mag = value;
    if (mode == itad_pkg::MODE_SDEC && mag[itad_pkg::VALUE_W-1]) begin
      mag = -mag;
    end
    for (int unsigned k = 0; k < n; k++) begin
      if (mode == itad_pkg::MODE_HEX || mode == MODE_HEX_ALT) begin
        nib = mag[itad_pkg::NIB_W-1:0];
        if (nib < 4'd10) begin
          digits[k] = itad_pkg::CHAR_ZERO + 8'(nib);
        end else begin
          digits[k] = (upper ? itad_pkg::CHAR_UPPER : itad_pkg::CHAR_LOWER)
                      + 8'(nib) - 8'd10;
        end
        mag = mag >> itad_pkg::NIB_W;
      end else begin
        digits[k] = itad_pkg::CHAR_ZERO + 8'(mag % 64'd10);
        mag = mag / 64'd10;
      end
    end
    for (int unsigned k = 0; k < n; k++) begin
      w.ch   = digits[n-1-k];
      w.last = (k + 1 == n);
      char_expect_q.push_back(w);
    end
  endfunction

  function automatic void add_row(input logic [itad_pkg::MODE_W-1:0] mode,
                                  input logic [itad_pkg::VALUE_W-1:0] value,
                                  input logic [itad_pkg::DCNT_W-1:0] count,
                                  input logic upper,
                                  input bit typed,
                                  input string text);
    conv_row_t r;
    r.mode  = mode;
    r.value = value;
    r.count = count;
    r.upper = upper;
    r.typed = typed;
    r.text  = text;
    conv_rows.push_back(r);
  endfunction

  // Offer one request word; called and left at a falling edge.
  task automatic send_request(input conv_row_t r);
    char_word_t w;
    if (idle_en && $urandom_range(0, 2) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    req_if.valid       <= 1'b1;
    req_if.mode        <= r.mode;
    req_if.value       <= r.value;
    req_if.digit_count <= r.count;
    req_if.upper_case  <= r.upper;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    if (r.typed) begin
      for (int i = 0; i < r.text.len(); i++) begin
        w.ch   = r.text[i];
        w.last = (i == r.text.len() - 1);
        char_expect_q.push_back(w);
      end
    end else begin
      predict_digits(r.mode, r.value, r.count, r.upper);
    end
    @(negedge clk_i);
  endtask

  // Receiver: random stall bursts while idling is enabled.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      chr_if.ready <= 1'b0;
    end else if (stall_left != 0) begin
      chr_if.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      chr_if.ready <= 1'b0;
      stall_left   <= $urandom_range(0, 3);
    end else begin
      chr_if.ready <= 1'b1;
    end
  end

  // Check each character word against the oldest expected word.
  always @(posedge clk_i) begin
    char_word_t w;
    if (rst_ni && chr_if.valid && chr_if.ready) begin
      if (char_expect_q.size() == 0) begin
        $error("character: unexpected word %h (last %b)", chr_if.character, chr_if.last);
        fail_cnt++;
      end else begin
        w = char_expect_q.pop_front();
        if (chr_if.character !== w.ch) begin
          $error("character: expected %h, actual %h", w.ch, chr_if.character);
          fail_cnt++;
        end
        if (chr_if.last !== w.last) begin
          $error("last: expected %b, actual %b", w.last, chr_if.last);
          fail_cnt++;
        end
      end
    end
  end

  // Watchdog on cycles with no word moving on either side.
  always @(posedge clk_i) begin
    if (!rst_ni || (req_if.valid && req_if.ready) || (chr_if.valid && chr_if.ready)) begin
      quiet_cnt <= 0;
    end else if (quiet_cnt >= WATCHDOG_MAX) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cnt <= quiet_cnt + 1;
    end
  end

  initial begin
    conv_row_t r;
    logic [itad_pkg::VALUE_W-1:0] v;
    int unsigned sel;

    clk_i              = 1'b0;
    rst_ni             = 1'b0;
    req_if.valid       = 1'b0;
    req_if.mode        = itad_pkg::MODE_SDEC;
    req_if.value       = '0;
    req_if.digit_count = '0;
    req_if.upper_case  = 1'b0;
    chr_if.ready       = 1'b0;
    fail_cnt           = 0;
    stall_left         = 0;
    quiet_cnt          = 0;
    idle_en            = 1'b1;

    add_row(itad_pkg::MODE_UDEC, 64'd0, 6'd1, 1'b0, 1, "0");
    add_row(itad_pkg::MODE_UDEC, 64'hFFFF_FFFF_FFFF_FFFF, 6'd20, 1'b0, 1,
            "18446744073709551615");
    add_row(itad_pkg::MODE_UDEC, 64'hFFFF_FFFF_FFFF_FFFF, 6'd32, 1'b0, 1,
            {"000000000000", "18446744073709551615"});
    add_row(itad_pkg::MODE_UDEC, 64'hFFFF_FFFF_FFFF_FFFF, 6'd5, 1'b0, 1, "51615");
    add_row(itad_pkg::MODE_UDEC, 64'hFFFF_FFFF_FFFF_FFFF, 6'd63, 1'b1, 0, "");
    add_row(itad_pkg::MODE_UDEC, 64'h8000_0000_0000_0000, 6'd20, 1'b0, 0, "");
    add_row(itad_pkg::MODE_UDEC, 64'd9876543210, 6'd10, 1'b1, 1, "9876543210");
    add_row(itad_pkg::MODE_SDEC, 64'h8000_0000_0000_0000, 6'd19, 1'b0, 1,
            "9223372036854775808");
    add_row(itad_pkg::MODE_SDEC, 64'h7FFF_FFFF_FFFF_FFFF, 6'd19, 1'b0, 1,
            "9223372036854775807");
    add_row(itad_pkg::MODE_SDEC, 64'hFFFF_FFFF_FFFF_FFFF, 6'd3, 1'b0, 1, "001");
    add_row(itad_pkg::MODE_SDEC, 64'd42, 6'd2, 1'b1, 1, "42");
    add_row(itad_pkg::MODE_SDEC, 64'h8000_0000_0000_0001, 6'd63, 1'b1, 0, "");
    add_row(itad_pkg::MODE_HEX, 64'hFFFF_FFFF_FFFF_FFFF, 6'd16, 1'b1, 1,
            "FFFFFFFFFFFFFFFF");
    add_row(itad_pkg::MODE_HEX, 64'hFFFF_FFFF_FFFF_FFFF, 6'd16, 1'b0, 1,
            "ffffffffffffffff");
    add_row(itad_pkg::MODE_HEX, 64'h0123_4567_89AB_CDEF, 6'd16, 1'b0, 1,
            "0123456789abcdef");
    add_row(itad_pkg::MODE_HEX, 64'h0123_4567_89AB_CDEF, 6'd16, 1'b1, 1,
            "0123456789ABCDEF");
    add_row(itad_pkg::MODE_HEX, 64'h0000_0000_0000_000F, 6'd1, 1'b1, 1, "F");
    add_row(itad_pkg::MODE_HEX, 64'd0, 6'd32, 1'b0, 0, "");
    add_row(itad_pkg::MODE_HEX, 64'hDEAD_BEEF_CAFE_F00D, 6'd33, 1'b1, 0, "");
    add_row(MODE_HEX_ALT, 64'h0000_0000_0000_ABCD, 6'd4, 1'b1, 1, "ABCD");
    add_row(MODE_HEX_ALT, 64'h0000_0000_0000_ABCD, 6'd4, 1'b0, 1, "abcd");
    add_row(itad_pkg::MODE_UDEC, 64'd1234, 6'd0, 1'b0, 1, "");
    add_row(itad_pkg::MODE_HEX, 64'h1234, 6'd0, 1'b1, 1, "");
    add_row(itad_pkg::MODE_SDEC, 64'hFFFF_FFFF_FFFF_FF85, 6'd0, 1'b0, 1, "");

    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (conv_rows[i]) begin
      send_request(conv_rows[i]);
    end

    for (int unsigned i = 0; i < RANDOM_WORDS; i++) begin
      if (i == RANDOM_WORDS - QUIET_WORDS) begin
        idle_en = 1'b0;
      end
      sel = $urandom_range(0, 9);
      case (sel)
        0, 1:    v = 64'($urandom_range(0, 999));
        2:       v = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 20));
        3:       v = 64'h8000_0000_0000_0000 + 64'($urandom_range(0, 20)) - 64'd10;
        4:       v = (64'd1 << $urandom_range(0, 63)) - 64'($urandom_range(0, 1));
        default: v = {$urandom, $urandom};
      endcase
      r.value = v;
      r.mode  = 2'($urandom_range(0, 3));
      r.upper = 1'($urandom_range(0, 1));
      r.typed = 0;
      r.text  = "";
      sel = $urandom_range(0, 19);
      if (sel == 0) begin
        r.count = '0;
      end else if (sel < 3) begin
        r.count = 6'($urandom_range(33, 63));
      end else if (sel < 6) begin
        r.count = 6'($urandom_range(21, 32));
      end else begin
        r.count = 6'($urandom_range(1, 20));
      end
      send_request(r);
    end
    req_if.valid <= 1'b0;

    while (char_expect_q.size() != 0) @(posedge clk_i);
    // let a trailing zero-count request finish and catch stray words
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fail_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
